>>> design/vlis_pkg.sv
// Shared types, constants and helper functions of the virtual address level index split.
package vlis_pkg;

    localparam int XLEN           = 64;   // address and index width
    localparam int WID_W          = 7;    // width of one level width field
    localparam int LVL_W          = 3;    // walk level and level count width
    localparam int SPACE_W        = 4;    // address space code width
    localparam int SLOTS          = 6;    // index outputs: five levels and a remainder
    localparam int CIDX_W         = 3;    // configuration register index width
    localparam int CDATA_W        = 64;   // configuration write data width
    localparam int WIDTHS_W       = 35;   // packed level widths
    localparam int MAX_LEVELS_DEF = 5;
    localparam int ADDR_WIDTH_DEF = 64;

    // Saturated offset: any shift at or beyond this gives zero
    localparam logic [WID_W-1:0] OFF_SAT     = WID_W'(XLEN);
    localparam logic [SPACE_W-1:0] SPACE_KPHYS = '0;

    typedef enum logic [2:0] {
        MODE_NONE   = 3'd0,
        MODE_LINEAR = 3'd1,
        MODE_SPLIT  = 3'd2,
        MODE_UCHK   = 3'd3,
        MODE_SCHK   = 3'd4
    } t_mode;

    typedef enum logic [CIDX_W-1:0] {
        CFG_MODE        = 3'd0,
        CFG_LEVEL_COUNT = 3'd1,
        CFG_LEVEL_WIDTHS = 3'd2,
        CFG_ROOT_ADDR   = 3'd3,
        CFG_ROOT_SPACE  = 3'd4,
        CFG_LINEAR_OFS  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]          mode;
        logic [LVL_W-1:0]    level_count;
        logic [WIDTHS_W-1:0] level_widths;
        logic [XLEN-1:0]     root_addr;
        logic [SPACE_W-1:0]  root_space;
        logic signed [XLEN-1:0] linear_offset;
    } t_cfg;

    typedef struct packed {
        logic                         status;
        logic [LVL_W-1:0]             level;
        logic [XLEN-1:0]              base;
        logic [SPACE_W-1:0]           space;
        logic [SLOTS-1:0][XLEN-1:0]   index;
    } t_walk;

    // Right shift that yields zero for a shift of 64 or more
    function automatic logic [XLEN-1:0] shr_sat(input logic [XLEN-1:0] v,
                                                input logic [WID_W-1:0] n);
        shr_sat = n[WID_W-1] ? '0 : (v >> n[WID_W-2:0]);
    endfunction

    // Mask of the n low bits, all ones for n of 64 or more
    function automatic logic [XLEN-1:0] low_mask(input logic [WID_W-1:0] n);
        low_mask = n[WID_W-1] ? '1 : ((XLEN'(1) << n[WID_W-2:0]) - XLEN'(1));
    endfunction

endpackage

>>> design/vlis_cfg.sv
// Configuration register file of the level index split.
module vlis_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vlis_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [vlis_pkg::CDATA_W-1:0]  i_cfg_data,
    output vlis_pkg::t_cfg                o_cfg
);

    vlis_pkg::t_cfg r_cfg;
    vlis_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                vlis_pkg::CFG_MODE:         n_cfg.mode          = i_cfg_data[2:0];
                vlis_pkg::CFG_LEVEL_COUNT:  n_cfg.level_count   =
                                                i_cfg_data[vlis_pkg::LVL_W-1:0];
                vlis_pkg::CFG_LEVEL_WIDTHS: n_cfg.level_widths  =
                                                i_cfg_data[vlis_pkg::WIDTHS_W-1:0];
                vlis_pkg::CFG_ROOT_ADDR:    n_cfg.root_addr     = i_cfg_data;
                vlis_pkg::CFG_ROOT_SPACE:   n_cfg.root_space    =
                                                i_cfg_data[vlis_pkg::SPACE_W-1:0];
                vlis_pkg::CFG_LINEAR_OFS:   n_cfg.linear_offset = $signed(i_cfg_data);
                default:                    n_cfg = r_cfg;   // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= vlis_pkg::MODE_NONE;
            r_cfg.level_count   <= vlis_pkg::LVL_W'(1);
            r_cfg.level_widths  <= '0;
            r_cfg.root_addr     <= '0;
            r_cfg.root_space    <= '0;
            r_cfg.linear_offset <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/vlis_split.sv
// Combinational address split: level offsets, per-level indices, remainder and range check.
module vlis_split #(
    parameter int MAX_LEVELS = vlis_pkg::MAX_LEVELS_DEF,
    parameter int ADDR_WIDTH = vlis_pkg::ADDR_WIDTH_DEF
) (
    input  vlis_pkg::t_cfg               i_cfg,
    input  logic [vlis_pkg::XLEN-1:0]    i_vaddr,
    output vlis_pkg::t_walk              o_walk
);

    localparam logic [vlis_pkg::XLEN-1:0] ADDR_MASK =
        {vlis_pkg::XLEN{1'b1}} >> (vlis_pkg::XLEN - ADDR_WIDTH);

    logic [vlis_pkg::XLEN-1:0]  addr;
    logic [vlis_pkg::LVL_W-1:0] levels;
    logic [vlis_pkg::WID_W-1:0] wid     [MAX_LEVELS];
    logic [vlis_pkg::WID_W-1:0] off     [MAX_LEVELS+1];
    logic [vlis_pkg::XLEN-1:0]  lvl_idx [MAX_LEVELS];
    logic [vlis_pkg::WID_W-1:0] off_rem;
    logic [vlis_pkg::XLEN-1:0]  rem;
    logic [vlis_pkg::WID_W-1:0] top_w;
    logic [vlis_pkg::WID_W-1:0] top_w_m1;
    logic [vlis_pkg::XLEN-1:0]  top_idx;
    logic                       sign;
    logic [vlis_pkg::XLEN-1:0]  ext;
    logic [vlis_pkg::SLOTS-1:0][vlis_pkg::XLEN-1:0] slot;

    assign addr   = i_vaddr & ADDR_MASK;
    assign levels = (i_cfg.level_count > vlis_pkg::LVL_W'(MAX_LEVELS))
                  ? vlis_pkg::LVL_W'(MAX_LEVELS) : i_cfg.level_count;

    // Start bit of each level: running sum of widths, saturated at 64
    always_comb begin
        logic [vlis_pkg::WID_W:0] sum;
        off[0] = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            wid[i] = i_cfg.level_widths[vlis_pkg::WID_W*i +: vlis_pkg::WID_W];
            sum    = {1'b0, off[i]} + {1'b0, wid[i]};
            off[i+1] = (sum > {1'b0, vlis_pkg::OFF_SAT}) ? vlis_pkg::OFF_SAT
                                                         : sum[vlis_pkg::WID_W-1:0];
            lvl_idx[i] = vlis_pkg::shr_sat(addr, off[i]) & vlis_pkg::low_mask(wid[i]);
        end
    end

    // Remainder offset and top level, picked by the active level count
    always_comb begin
        off_rem = off[0];
        top_w   = '0;
        top_idx = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (levels == vlis_pkg::LVL_W'(i + 1)) begin
                off_rem = off[i+1];
                top_w   = wid[i];
                top_idx = lvl_idx[i];
            end
        end
    end

    assign rem      = vlis_pkg::shr_sat(addr, off_rem);
    assign top_w_m1 = top_w - vlis_pkg::WID_W'(1);
    // zero-width or overwide top level has no sign bit
    assign sign     = (top_w != '0) && !top_w_m1[vlis_pkg::WID_W-1]
                    && top_idx[top_w_m1[vlis_pkg::WID_W-2:0]];
    assign ext      = (sign && !off_rem[vlis_pkg::WID_W-1])
                    ? vlis_pkg::shr_sat('1, off_rem) : '0;

    for (genvar j = 0; j < vlis_pkg::SLOTS; j++) begin : g_slot
        if (j < MAX_LEVELS) begin : g_lvl
            assign slot[j] = (vlis_pkg::LVL_W'(j) < levels) ? lvl_idx[j]
                           : (vlis_pkg::LVL_W'(j) == levels) ? rem : '0;
        end else begin : g_top
            assign slot[j] = (vlis_pkg::LVL_W'(j) == levels) ? rem : '0;
        end
    end

    always_comb begin
        o_walk = '0;
        case (i_cfg.mode)
            vlis_pkg::MODE_LINEAR: begin
                o_walk.level    = vlis_pkg::LVL_W'(1);
                o_walk.base     = ~$unsigned(i_cfg.linear_offset) + vlis_pkg::XLEN'(1);
                o_walk.space    = vlis_pkg::SPACE_KPHYS;
                o_walk.index[0] = addr;
            end
            vlis_pkg::MODE_SPLIT, vlis_pkg::MODE_UCHK, vlis_pkg::MODE_SCHK: begin
                o_walk.level = levels;
                o_walk.base  = i_cfg.root_addr;
                o_walk.space = i_cfg.root_space;
                o_walk.index = slot;
                if (i_cfg.mode == vlis_pkg::MODE_UCHK) begin
                    o_walk.status = (rem != '0);
                end else if (i_cfg.mode == vlis_pkg::MODE_SCHK) begin
                    o_walk.status = (rem != ext);
                end
            end
            default: o_walk = '0;   // none mode and unused codes
        endcase
    end

endmodule

>>> design/vaddr_level_index_split.sv
// Top level of the virtual address level index split: request pipeline and output register.
//
// Usage
//  - Request channel: i_in_valid / o_in_ready carry one virtual address (i_vaddr).
//  - Result channel: o_out_valid / i_out_ready carry the walk start: status,
//    walk level, base address and space, and six index slots.
//  - Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx in the
//    same edge; write only while no request is in flight.
//  - Path: an accepted request is held in the input register, split, and then
//    captured in the result register, which drives the result channel.
//  - Throughput: one request per cycle while results are taken. The input
//    register and the result register form a two-stage pipeline; the split itself
//    is one pass of parallel barrel shifters set by running sums of the level widths.
//  - Stall: while the result is held, the input register still takes one more
//    request; o_in_ready drops only when both stages are full.
//  - Reset: both stages empty, mode none, level count one, other config registers zero.
module vaddr_level_index_split #(
    parameter int MAX_LEVELS = vlis_pkg::MAX_LEVELS_DEF,
    parameter int ADDR_WIDTH = vlis_pkg::ADDR_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [vlis_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  logic [vlis_pkg::CDATA_W-1:0]   i_cfg_data,
    // request
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [vlis_pkg::XLEN-1:0]      i_vaddr,
    // result
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_status,
    output logic [vlis_pkg::LVL_W-1:0]     o_walk_level,
    output logic [vlis_pkg::XLEN-1:0]      o_base_addr,
    output logic [vlis_pkg::SPACE_W-1:0]   o_base_space,
    output logic [vlis_pkg::XLEN-1:0]      o_index_0,
    output logic [vlis_pkg::XLEN-1:0]      o_index_1,
    output logic [vlis_pkg::XLEN-1:0]      o_index_2,
    output logic [vlis_pkg::XLEN-1:0]      o_index_3,
    output logic [vlis_pkg::XLEN-1:0]      o_index_4,
    output logic [vlis_pkg::XLEN-1:0]      o_index_5
);

    vlis_pkg::t_cfg  cfg;
    vlis_pkg::t_walk walk;

    logic                      r_in_valid;
    logic [vlis_pkg::XLEN-1:0] r_vaddr;
    logic                      r_out_valid;
    vlis_pkg::t_walk           r_walk;
    logic                      out_free;   // result register can take a new value
    logic                      advance;    // input stage moves into the result register
    logic                      in_take;

    vlis_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    vlis_split #(
        .MAX_LEVELS (MAX_LEVELS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_split (
        .i_cfg   (cfg),
        .i_vaddr (r_vaddr),
        .o_walk  (walk)
    );

    // Handshake: input stage passes its request on whenever the result register is free
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_vaddr <= i_vaddr;
        end
        if (advance) begin
            r_walk <= walk;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_walk.status;
    assign o_walk_level = r_walk.level;
    assign o_base_addr  = r_walk.base;
    assign o_base_space = r_walk.space;
    assign o_index_0    = r_walk.index[0];
    assign o_index_1    = r_walk.index[1];
    assign o_index_2    = r_walk.index[2];
    assign o_index_3    = r_walk.index[3];
    assign o_index_4    = r_walk.index[4];
    assign o_index_5    = r_walk.index[5];

    // Back-pressure only when both stages hold a request
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("request refused with a free stage");

    // An accepted request lands in the input stage
    a_take_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted request lost");

    // A request in the input stage moves on when the result register is free
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("request dropped between stages");

    // Walk level never exceeds the supported depth
    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_walk_level <= vlis_pkg::LVL_W'(MAX_LEVELS)))
        else $error("walk level above table depth");

    // Top slot holds a remainder only under a full five-level walk
    a_top_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_walk_level < vlis_pkg::LVL_W'(vlis_pkg::SLOTS - 1)))
        |-> (o_index_5 == '0))
        else $error("index slot above remainder not zero");

endmodule

>>> test/vaddr_level_index_split_test.sv
// Self-checking testbench of the virtual address level index split, with a walk start predictor.
module vaddr_level_index_split_test;
    import vlis_pkg::*;

    // Handshake pacing and run limits
    localparam int GAP_MAX      = 16;     // longest idle per request on either side
    localparam int HOLD_CYCLES  = 300;    // one long receiver hold-off to fill the pipe
    localparam int STUCK_LIMIT  = 3000;   // cycles with no handshake before giving up
    localparam int RANDOM_ITEMS = 1900;
    localparam int TAIL_CYCLES  = 4;      // past the two-stage latency

    // Register indexes the block does not decode, and the highest mode code
    localparam logic [CIDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam logic [2:0]        MODE_SPARE  = 3'd7;

    // Predictor of the walk start and store of walk starts still owed by the block
    class walk_start_book;
        t_cfg  regs;
        t_walk walks_due[$];
        int    errors;

        function new();
            regs = '0;
            regs.level_count = 1;
            errors = 0;
        endfunction

        // Narrow registers keep only their low bits; spare indexes are dropped
        function void set_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
            case (idx)
                CFG_MODE:         regs.mode          = data[2:0];
                CFG_LEVEL_COUNT:  regs.level_count   = data[LVL_W-1:0];
                CFG_LEVEL_WIDTHS: regs.level_widths  = data[WIDTHS_W-1:0];
                CFG_ROOT_ADDR:    regs.root_addr     = data;
                CFG_ROOT_SPACE:   regs.root_space    = data[SPACE_W-1:0];
                CFG_LINEAR_OFS:   regs.linear_offset = data;
                default: ;
            endcase
        endfunction

        // Shifts of 64 or more give zero in SystemVerilog, so wide levels need no
        // special handling: a mask of 1 << w minus one turns into all ones.
        function t_walk split_walk(logic [XLEN-1:0] va);
            t_walk            w;
            int               levels;
            int               total;
            logic [WID_W-1:0] wd;
            logic [XLEN-1:0]  rest;
            logic [XLEN-1:0]  ext;
            logic [XLEN-1:0]  top;
            logic             sign;
            w = '0;
            case (regs.mode)
                MODE_LINEAR: begin
                    w.level    = 1;
                    w.base     = XLEN'(0) - regs.linear_offset;
                    w.space    = SPACE_KPHYS;
                    w.index[0] = va;
                end
                MODE_SPLIT, MODE_UCHK, MODE_SCHK: begin
                    levels = (regs.level_count > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF
                                                                 : int'(regs.level_count);
                    rest  = va;
                    total = 0;
                    for (int i = 0; i < levels; i++) begin
                        wd = regs.level_widths[WID_W*i +: WID_W];
                        w.index[i] = rest & ((XLEN'(1) << wd) - XLEN'(1));
                        rest  = rest >> wd;
                        total += int'(wd);
                    end
                    w.index[levels] = rest;
                    // canonical check: sign of the top level's highest bit
                    sign = 1'b0;
                    if (levels > 0) begin
                        wd = regs.level_widths[WID_W*(levels-1) +: WID_W];
                        if (wd != 0) begin
                            top  = w.index[levels-1] >> (wd - 1);
                            sign = top[0];
                        end
                    end
                    ext = (sign && total < XLEN) ? ({XLEN{1'b1}} >> total) : '0;
                    if (regs.mode == MODE_UCHK)
                        w.status = (rest != '0);
                    else if (regs.mode == MODE_SCHK)
                        w.status = (rest != ext);
                    w.level = LVL_W'(levels);
                    w.base  = regs.root_addr;
                    w.space = regs.root_space;
                end
                default: ;  // none mode and unused codes give all zeros
            endcase
            return w;
        endfunction

        function void note_request(logic [XLEN-1:0] va);
            walks_due.push_back(split_walk(va));
        endfunction

        function int pending();
            return walks_due.size();
        endfunction

        function bit field_ok(string name, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
            if (want === got)
                return 1'b1;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            return 1'b0;
        endfunction

        function void check_walk(t_walk got);
            t_walk want;
            bit    ok;
            if (walks_due.size() == 0) begin
                $display("%0t: walk start with no request waiting: expected none actual base %h",
                         $time, got.base);
                errors++;
                return;
            end
            want = walks_due.pop_front();
            ok = field_ok("status", XLEN'(want.status), XLEN'(got.status));
            ok = field_ok("walk_level", XLEN'(want.level), XLEN'(got.level)) && ok;
            ok = field_ok("base_addr", want.base, got.base) && ok;
            ok = field_ok("base_space", XLEN'(want.space), XLEN'(got.space)) && ok;
            for (int k = 0; k < SLOTS; k++)
                ok = field_ok($sformatf("index_%0d", k), want.index[k], got.index[k]) && ok;
            if (!ok)
                errors++;
        endfunction
    endclass

    // Block inputs, all known from time zero
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CIDX_W-1:0]   cfg_idx   = '0;
    logic [CDATA_W-1:0]  cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic [XLEN-1:0]     vaddr     = '0;
    logic                out_ready = 1'b0;

    logic                in_ready;
    logic                out_valid;
    logic                status;
    logic [LVL_W-1:0]    walk_level;
    logic [XLEN-1:0]     base_addr;
    logic [SPACE_W-1:0]  base_space;
    logic [XLEN-1:0]     index_0, index_1, index_2, index_3, index_4, index_5;

    walk_start_book book;
    bit             calm       = 1'b0;   // phase with no idling on either side
    bit             hold_off   = 1'b0;   // receiver takes one long pause when set
    int             split_bits = 0;      // bits taken by the levels in use
    int             stuck      = 0;

    vaddr_level_index_split u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_vaddr      (vaddr),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (status),
        .o_walk_level (walk_level),
        .o_base_addr  (base_addr),
        .o_base_space (base_space),
        .o_index_0    (index_0),
        .o_index_1    (index_1),
        .o_index_2    (index_2),
        .o_index_3    (index_3),
        .o_index_4    (index_4),
        .o_index_5    (index_5)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Watchdog: no request, result or register write for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
            stuck <= 0;
        end else if (stuck == STUCK_LIMIT) begin
            $display("vaddr_level_index_split: mismatch");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    function automatic logic [WIDTHS_W-1:0] pack5(int w0, int w1, int w2, int w3, int w4);
        return {WID_W'(w4), WID_W'(w3), WID_W'(w2), WID_W'(w1), WID_W'(w0)};
    endfunction

    // Addresses biased towards passing the range checks so the split is exercised
    // on well-formed walks; the rest is raw noise and single-bit extremes.
    function automatic logic [XLEN-1:0] shape_addr(int total);
        logic [XLEN-1:0] a;
        a = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0, 1: begin
                if (total > 0 && total < XLEN)
                    a = a[total-1] ? (a | ({XLEN{1'b1}} << total))
                                   : (a & ~({XLEN{1'b1}} << total));
            end
            2: begin
                if (total < XLEN)
                    a = a & ~({XLEN{1'b1}} << total);
            end
            3: begin
                case ($urandom_range(0, 3))
                    0: a = '0;
                    1: a = '1;
                    2: a = XLEN'(1) << $urandom_range(0, XLEN-1);
                    default: a = ~(XLEN'(1) << $urandom_range(0, XLEN-1));
                endcase
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // One register write; bits above the register's width carry junk
    task automatic put_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] value,
                           input int width);
        logic [CDATA_W-1:0] keep;
        logic [CDATA_W-1:0] data;
        keep = (width >= CDATA_W) ? '1 : ~({CDATA_W{1'b1}} << width);
        data = ({$urandom, $urandom} & ~keep) | (value & keep);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        book.set_reg(idx, data);
    endtask

    // Stop offering and wait until every owed walk start has been taken
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (book.pending() != 0);
    endtask

    task automatic configure(input logic [2:0] mode, input logic [LVL_W-1:0] count,
                             input logic [WIDTHS_W-1:0] widths, input logic [XLEN-1:0] root,
                             input logic [SPACE_W-1:0] space, input logic [XLEN-1:0] ofs,
                             input bit spare);
        int levels;
        drain();
        put_reg(CFG_MODE, XLEN'(mode), $bits(t_mode));
        put_reg(CFG_LEVEL_COUNT, XLEN'(count), LVL_W);
        put_reg(CFG_LEVEL_WIDTHS, XLEN'(widths), WIDTHS_W);
        put_reg(CFG_ROOT_ADDR, root, XLEN);
        put_reg(CFG_ROOT_SPACE, XLEN'(space), SPACE_W);
        put_reg(CFG_LINEAR_OFS, ofs, XLEN);
        if (spare) begin
            put_reg(CFG_SPARE_A, '1, XLEN);
            put_reg(CFG_SPARE_B, {$urandom, $urandom}, XLEN);
        end
        cfg_we <= 1'b0;
        levels = (count > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF : int'(count);
        split_bits = 0;
        for (int i = 0; i < levels; i++)
            split_bits += int'(widths[WID_W*i +: WID_W]);
    endtask

    task automatic random_config();
        logic [2:0]          mode;
        logic [LVL_W-1:0]    count;
        logic [WIDTHS_W-1:0] widths;
        int                  w[MAX_LEVELS_DEF];
        int                  levels;
        int                  lower;
        case ($urandom_range(0, 9))
            0:       mode = MODE_NONE;
            1:       mode = MODE_LINEAR;
            2:       mode = 3'($urandom_range(MODE_SCHK + 1, MODE_SPARE));
            3, 4:    mode = MODE_SPLIT;
            5, 6:    mode = MODE_UCHK;
            default: mode = MODE_SCHK;
        endcase
        count = ($urandom_range(0, 9) < 8) ? LVL_W'($urandom_range(1, MAX_LEVELS_DEF))
                                           : LVL_W'($urandom_range(0, 7));
        for (int i = 0; i < MAX_LEVELS_DEF; i++) begin
            case ($urandom_range(0, 9))
                0:       w[i] = 0;
                1:       w[i] = $urandom_range(0, 127);
                default: w[i] = $urandom_range(1, 16);
            endcase
        end
        // now and then the levels in use fill the address exactly
        levels = (count > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF : int'(count);
        if (levels > 0 && $urandom_range(0, 4) == 0) begin
            lower = 0;
            for (int i = 0; i < levels - 1; i++)
                lower += w[i];
            if (lower <= XLEN)
                w[levels-1] = XLEN - lower;
        end
        widths = pack5(w[0], w[1], w[2], w[3], w[4]);
        configure(mode, count, widths, {$urandom, $urandom}, 4'($urandom_range(0, 15)),
                  {$urandom, $urandom}, 1'b0);
    endtask

    // Offer one request, idling first for a drawn number of cycles
    task automatic offer(input logic [XLEN-1:0] va);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        vaddr    <= va;
        do @(posedge clk); while (in_ready !== 1'b1);
        book.note_request(va);
    endtask

    // Result side: random stalls, one long hold-off on request, check every result
    initial begin
        int    gap;
        t_walk got;
        do @(posedge clk); while (!rst_n);
        forever begin
            gap = hold_off ? HOLD_CYCLES : draw_gap();
            hold_off = 1'b0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            got.status   = status;
            got.level    = walk_level;
            got.base     = base_addr;
            got.space    = base_space;
            got.index[0] = index_0;
            got.index[1] = index_1;
            got.index[2] = index_2;
            got.index[3] = index_3;
            got.index[4] = index_4;
            got.index[5] = index_5;
            book.check_walk(got);
        end
    end

    // Request side and phase sequencing
    initial begin
        int done;
        int phase;
        int n;
        book = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset state: none mode
        offer('0);
        offer('1);

        // linear mode at both offset extremes; table registers at their extremes
        configure(MODE_LINEAR, 1, '0, '0, '0, 64'h8000_0000_0000_0000, 1'b0);
        offer('0);
        offer('1);
        configure(MODE_LINEAR, 5, '1, '1, 4'hF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        offer(64'h0123_4567_89AB_CDEF);

        // five levels of 48 bits with canonical check: both halves, both holes
        configure(MODE_SCHK, 5, pack5(12, 9, 9, 9, 9), 64'h1000, 4'h3, '0, 1'b0);
        offer(64'hFFFF_8000_0000_0000);
        offer(64'h0000_7FFF_FFFF_FFFF);
        offer(64'h0000_8000_0000_0000);
        offer(64'hFFFF_7FFF_FFFF_FFFF);

        // unsigned check just inside and just past the table reach
        configure(MODE_UCHK, 3, pack5(12, 9, 9, 0, 0), '1, 4'hF, '0, 1'b0);
        offer(64'h0000_0000_3FFF_FFFF);
        offer(64'h0000_0000_4000_0000);

        // no levels: whole address is the remainder, sign taken as clear
        configure(MODE_SCHK, 0, pack5(12, 9, 9, 9, 9), 64'h2000, 4'h1, '0, 1'b0);
        offer('0);
        offer('1);

        // count saturates, every width at its widest
        configure(MODE_SCHK, 7, '1, 64'h3000, 4'h2, '0, 1'b0);
        offer('1);
        offer(64'h8000_0000_0000_0000);

        // widths summing to exactly 64: empty remainder always passes
        configure(MODE_SCHK, 4, pack5(16, 16, 16, 16, 0), 64'h4000, 4'h5, '0, 1'b0);
        offer('1);
        offer(64'h8000_0000_0000_0000);

        // zero-width top level has no sign
        configure(MODE_SCHK, 2, pack5(12, 0, 0, 0, 0), 64'h5000, 4'h6, '0, 1'b0);
        offer('1);
        offer(64'h0000_0000_0000_0800);

        // a level wider than what is left swallows the rest
        configure(MODE_SPLIT, 5, pack5(3, 70, 5, 5, 5), 64'h6000, 4'h7, '0, 1'b0);
        offer('1);

        // unused mode code
        configure(MODE_SPARE, 3, pack5(12, 9, 9, 0, 0), 64'h7000, 4'h8, 64'h1234, 1'b0);
        offer(64'hDEAD_BEEF_0000_1234);

        // random phases, each with its own register setting
        done  = 0;
        phase = 0;
        while (done < RANDOM_ITEMS) begin
            random_config();
            calm = ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 100);
            if (phase == 2)
                hold_off = 1'b1;   // requests keep coming while results back up
            for (int k = 0; k < n; k++) begin
                if (phase == 4 && k == n / 2)
                    drain();       // sender pauses until the pipe is empty
                offer(shape_addr(split_bits));
            end
            done += n;
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("vaddr_level_index_split: match");
        else
            $display("vaddr_level_index_split: mismatch");
        $finish;
    end

endmodule

>>> sim.f
design/vlis_pkg.sv
design/vlis_cfg.sv
design/vlis_split.sv
design/vaddr_level_index_split.sv
test/vaddr_level_index_split_test.sv
